// ===== rtl/cpr_pkg.sv =====
// Shared constants, types and helper functions for the clock page replacement block.
`timescale 1ns / 1ps

package cpr_pkg;

    // Sizes of the frame table and of the page descriptors.
    localparam int NUM_FRAMES = 256;
    localparam int PID_BITS   = 16;
    localparam int VPN_BITS   = 36;

    localparam int FRAME_W = $clog2(NUM_FRAMES);
    localparam int RING_W  = $clog2(NUM_FRAMES + 1);
    localparam int CFG_W   = 9;
    localparam int CMP_W   = (CFG_W > RING_W) ? CFG_W : RING_W;
    localparam int ENTRY_W = PID_BITS + VPN_BITS;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(256);

    // Request codes.
    localparam logic ACT_TOUCH   = 1'b0;
    localparam logic ACT_REPLACE = 1'b1;

    // Status codes.
    localparam logic STAT_OK    = 1'b0;
    localparam logic STAT_RANGE = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_WRITE,
        ST_DONE
    } t_state;

    // Access to the descriptor memory.
    typedef struct packed {
        logic               re;
        logic               we;
        logic [FRAME_W-1:0] addr;
        logic [ENTRY_W-1:0] wdata;
    } t_ram_req;

    // Finished result handed to the output register.
    typedef struct packed {
        logic               load;
        logic               status;
        logic [FRAME_W-1:0] victim;
        logic               old_valid;
    } t_result;

    // Clamp the configured ring size to the range 1 .. NUM_FRAMES.
    function automatic logic [RING_W-1:0] ring_size(input logic [CFG_W-1:0] cfg);
        logic [CMP_W-1:0] v;
        v = CMP_W'(cfg);
        if (v == '0) begin
            return RING_W'(1);
        end
        if (v > CMP_W'(NUM_FRAMES)) begin
            return RING_W'(NUM_FRAMES);
        end
        return RING_W'(v);
    endfunction

    // Advance a frame index one step around the ring.
    function automatic logic [FRAME_W-1:0] next_frame(input logic [FRAME_W-1:0] h,
                                                      input logic [RING_W-1:0]  n);
        logic [RING_W-1:0] s;
        s = RING_W'(h) + RING_W'(1);
        return (s >= n) ? '0 : FRAME_W'(s);
    endfunction

endpackage

// ===== rtl/cpr_ram.sv =====
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module cpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_re,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/cpr_ctrl.sv =====
// Sequencer for the clock sweep: reference and valid bits, clock hand and ring size.
`timescale 1ns / 1ps

module cpr_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_action,
    input  logic [cpr_pkg::FRAME_W-1:0]   i_frame,
    input  logic [cpr_pkg::PID_BITS-1:0]  i_new_pid,
    input  logic [cpr_pkg::VPN_BITS-1:0]  i_new_vpn,
    input  logic                          i_cfg_we,
    input  logic [cpr_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_out_free,
    output cpr_pkg::t_ram_req             o_ram,
    output cpr_pkg::t_result              o_res
);

    import cpr_pkg::*;

    t_state                r_state, n_state;
    logic [NUM_FRAMES-1:0] r_ref, n_ref;
    logic [NUM_FRAMES-1:0] r_valid, n_valid;
    logic [FRAME_W-1:0]    r_hand, n_hand;
    logic [FRAME_W-1:0]    r_ptr, n_ptr;
    logic [CFG_W-1:0]      r_frames;
    logic                  r_status, n_status;
    logic                  r_old_valid, n_old_valid;
    logic [PID_BITS-1:0]   r_pid;
    logic [VPN_BITS-1:0]   r_vpn;
    logic [RING_W-1:0]     ring_n;
    logic                  accept;
    logic [FRAME_W-1:0]    step_ptr;

    assign ring_n   = ring_size(r_frames);
    assign accept   = i_valid && (r_state == ST_IDLE);
    assign o_ready  = (r_state == ST_IDLE);

    // The one shared ring stepper, used for the sweep pointer and the hand.
    assign step_ptr = next_frame(r_ptr, ring_n);

    // Next state and memory requests.
    always_comb begin
        n_state     = r_state;
        n_ref       = r_ref;
        n_valid     = r_valid;
        n_hand      = r_hand;
        n_ptr       = r_ptr;
        n_status    = r_status;
        n_old_valid = r_old_valid;
        o_ram       = '{re: 1'b0, we: 1'b0, addr: r_ptr, wdata: {r_pid, r_vpn}};
        o_res       = '{load: 1'b0, status: r_status, victim: r_ptr,
                        old_valid: r_old_valid};
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_status    = STAT_OK;
                    n_old_valid = 1'b0;
                    if (i_action == ACT_TOUCH) begin
                        // Touch: flag frames outside the ring, mark resident pages.
                        n_ptr = '0;
                        if (RING_W'(i_frame) >= ring_n) begin
                            n_status = STAT_RANGE;
                        end else if (r_valid[i_frame]) begin
                            n_ref[i_frame] = 1'b1;
                        end
                        n_state = ST_DONE;
                    end else begin
                        // Replace: start at the hand, or at frame 0 if the ring shrank.
                        n_ptr   = (RING_W'(r_hand) >= ring_n) ? '0 : r_hand;
                        n_state = ST_SWEEP;
                    end
                end
            end
            ST_SWEEP: begin
                if (r_ref[r_ptr]) begin
                    // Second chance: clear the bit and move on.
                    n_ref[r_ptr] = 1'b0;
                    n_ptr        = step_ptr;
                end else begin
                    // Victim found: fetch its old descriptor.
                    o_ram.re       = 1'b1;
                    n_old_valid    = r_valid[r_ptr];
                    n_valid[r_ptr] = 1'b1;
                    n_hand         = step_ptr;
                    n_state        = ST_WRITE;
                end
            end
            ST_WRITE: begin
                // Old descriptor is now in the read register; store the new page.
                o_ram.we = 1'b1;
                n_state  = ST_DONE;
            end
            ST_DONE: begin
                if (i_out_free) begin
                    o_res.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ref    <= '0;
            r_valid  <= '0;
            r_hand   <= '0;
            r_frames <= CFG_RESET;
        end else begin
            r_state <= n_state;
            r_ref   <= n_ref;
            r_valid <= n_valid;
            r_hand  <= n_hand;
            if (i_cfg_we) begin
                r_frames <= i_cfg_data;
            end
        end
    end

    // Request payload and result fields.
    always_ff @(posedge i_clk) begin
        r_ptr       <= n_ptr;
        r_status    <= n_status;
        r_old_valid <= n_old_valid;
        if (accept) begin
            r_pid <= i_new_pid;
            r_vpn <= i_new_vpn;
        end
    end

endmodule

// ===== rtl/clock_page_replacement.sv =====
// A touch goes from idle to the done state; a replace sweeps from the hand, clearing each set
// reference bit it passes, then reads the old descriptor and writes the new one before done.
// One request at a time: the block is ready again only after the result is loaded into the
// output register, and the done state waits while that register is full and not taken.
// Reset (synchronous, active low) clears all reference and valid bits and the hand,
// and sets the ring size to 256; descriptors of unfilled frames read as zero.
`timescale 1ns / 1ps

module clock_page_replacement (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_action,
    input  logic [cpr_pkg::FRAME_W-1:0]   i_frame,
    input  logic [cpr_pkg::PID_BITS-1:0]  i_new_pid,
    input  logic [cpr_pkg::VPN_BITS-1:0]  i_new_vpn,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_status,
    output logic [cpr_pkg::FRAME_W-1:0]   o_victim_frame,
    output logic                          o_old_valid,
    output logic [cpr_pkg::PID_BITS-1:0]  o_old_pid,
    output logic [cpr_pkg::VPN_BITS-1:0]  o_old_vpn,
    input  logic                          i_cfg_we,
    input  logic [cpr_pkg::CFG_W-1:0]     i_cfg_data
);

    import cpr_pkg::*;

    t_ram_req            ram_req;
    t_result             res;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic                out_free;
    logic                r_out_valid;
    logic                r_status;
    logic [FRAME_W-1:0]  r_victim;
    logic                r_old_valid;
    logic [PID_BITS-1:0] r_old_pid;
    logic [VPN_BITS-1:0] r_old_vpn;

    assign out_free = !r_out_valid || i_ready;

    // Sweep sequencer.
    cpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_action   (i_action),
        .i_frame    (i_frame),
        .i_new_pid  (i_new_pid),
        .i_new_vpn  (i_new_vpn),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_out_free (out_free),
        .o_ram      (ram_req),
        .o_res      (res)
    );

    // Page descriptor memory: pid in the upper bits, vpn in the lower.
    cpr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_FRAMES)
    ) u_desc_ram (
        .i_clk   (i_clk),
        .i_re    (ram_req.re),
        .i_we    (ram_req.we),
        .i_addr  (ram_req.addr),
        .i_wdata (ram_req.wdata),
        .o_rdata (ram_rdata)
    );

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload; the old descriptor is zero unless the victim held a page.
    always_ff @(posedge i_clk) begin
        if (res.load) begin
            r_status    <= res.status;
            r_victim    <= res.victim;
            r_old_valid <= res.old_valid;
            r_old_pid   <= res.old_valid ? ram_rdata[ENTRY_W-1:VPN_BITS] : '0;
            r_old_vpn   <= res.old_valid ? ram_rdata[VPN_BITS-1:0] : '0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_victim_frame = r_victim;
    assign o_old_valid    = r_old_valid;
    assign o_old_pid      = r_old_pid;
    assign o_old_vpn      = r_old_vpn;

endmodule

// ===== sim/clock_page_replacement_test.sv =====
// Self-checking testbench for the clock page replacement block.
`timescale 1ns / 1ps

module clock_page_replacement_test;
    import cpr_pkg::*;

    localparam int STALL_LIMIT     = 3000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SCRIPT_LEN      = 27;
    localparam int PHASES          = 11;
    localparam int RANDOM_PER_RING = 75;

    // One result of the block, in port order.
    typedef struct packed {
        logic                status;
        logic [FRAME_W-1:0]  victim;
        logic                old_valid;
        logic [PID_BITS-1:0] old_pid;
        logic [VPN_BITS-1:0] old_vpn;
    } t_page_result;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } t_row_kind;

    // One line of the directed script. Rows with chk set carry their expected result;
    // such rows always expect an empty victim descriptor, so only status and frame are typed.
    typedef struct packed {
        t_row_kind           kind;
        logic                act;
        logic [FRAME_W-1:0]  frame;
        logic [PID_BITS-1:0] pid;
        logic [VPN_BITS-1:0] vpn;
        logic [CFG_W-1:0]    ring;
        logic                chk;
        logic                w_status;
        logic [FRAME_W-1:0]  w_victim;
    } t_script_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic                i_action;
    logic [FRAME_W-1:0]  i_frame;
    logic [PID_BITS-1:0] i_new_pid;
    logic [VPN_BITS-1:0] i_new_vpn;
    logic                o_valid;
    logic                i_ready;
    logic                o_status;
    logic [FRAME_W-1:0]  o_victim_frame;
    logic                o_old_valid;
    logic [PID_BITS-1:0] o_old_pid;
    logic [VPN_BITS-1:0] o_old_vpn;
    logic                i_cfg_we;
    logic [CFG_W-1:0]    i_cfg_data;

    // Shadow copy of the frame table, hand and ring size.
    logic                referenced [NUM_FRAMES];
    logic                filled     [NUM_FRAMES];
    logic [PID_BITS-1:0] owner      [NUM_FRAMES];
    logic [VPN_BITS-1:0] vpage      [NUM_FRAMES];
    int                  hand_pos;
    logic [CFG_W-1:0]    ring_cfg;

    t_page_result awaited_results [$];
    t_script_row  script [SCRIPT_LEN];
    int           phase_ring [PHASES];

    bit idle_on;
    bit hold_off_req;
    int mismatch_count;
    int results_seen;
    int quiet_cycles;
    int touch_count;
    int off_ring_count;
    int replace_count;
    int longest_sweep;
    int full_laps;

    clock_page_replacement dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_frame        (i_frame),
        .i_new_pid      (i_new_pid),
        .i_new_vpn      (i_new_vpn),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_victim_frame (o_victim_frame),
        .o_old_valid    (o_old_valid),
        .o_old_pid      (o_old_pid),
        .o_old_vpn      (o_old_vpn),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Ring size as the block sees it: zero means one frame, oversize means all frames.
    function automatic int ring_frames();
        if (ring_cfg == '0) begin
            return 1;
        end
        if (ring_cfg > CFG_W'(NUM_FRAMES)) begin
            return NUM_FRAMES;
        end
        return int'(ring_cfg);
    endfunction

    // Apply one request to the shadow table and return the result it must give.
    function automatic t_page_result run_clock(input logic act, input logic [FRAME_W-1:0] frm,
                                               input logic [PID_BITS-1:0] pid,
                                               input logic [VPN_BITS-1:0] vpn);
        t_page_result r;
        int n;
        int h;
        int swept;
        r = '0;
        n = ring_frames();
        if (act == ACT_TOUCH) begin
            touch_count++;
            if (int'(frm) >= n) begin
                r.status = STAT_RANGE;
                off_ring_count++;
            end else if (filled[frm]) begin
                referenced[frm] = 1'b1;
            end
            return r;
        end

        // Second-chance sweep from the hand, which restarts at zero if the ring shrank.
        replace_count++;
        h = (hand_pos >= n) ? 0 : hand_pos;
        swept = 0;
        while (referenced[h]) begin
            referenced[h] = 1'b0;
            h = (h + 1 >= n) ? 0 : h + 1;
            swept++;
        end
        if (swept > longest_sweep) begin
            longest_sweep = swept;
        end
        if (swept >= n) begin
            full_laps++;
        end

        r.status    = STAT_OK;
        r.victim    = FRAME_W'(h);
        r.old_valid = filled[h];
        r.old_pid   = owner[h];
        r.old_vpn   = vpage[h];
        owner[h]      = pid;
        vpage[h]      = vpn;
        filled[h]     = 1'b1;
        referenced[h] = 1'b0;
        hand_pos = (h + 1 >= n) ? 0 : h + 1;
        return r;
    endfunction

    function automatic logic [PID_BITS-1:0] rand_pid();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            default: return PID_BITS'($urandom());
        endcase
    endfunction

    function automatic logic [VPN_BITS-1:0] rand_vpn();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            default: return VPN_BITS'({$urandom(), $urandom()});
        endcase
    endfunction

    // One line per mismatch; printing stops after a while but counting goes on.
    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        if (mismatch_count < 40) begin
            $display("MISMATCH result %0d: %s got 0x%0h expected 0x%0h",
                     results_seen, what, got, want);
        end
        mismatch_count++;
    endtask

    // Present one request, hold it until accepted, then record what it must produce.
    task automatic offer(input logic act, input logic [FRAME_W-1:0] frm,
                         input logic [PID_BITS-1:0] pid, input logic [VPN_BITS-1:0] vpn,
                         input logic chk, input t_page_result want);
        int gap;
        t_page_result r;
        gap = 0;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_action  <= act;
        i_frame   <= frm;
        i_new_pid <= pid;
        i_new_vpn <= vpn;
        @(posedge i_clk);
        while (o_ready !== 1'b1) begin
            @(posedge i_clk);
        end
        r = run_clock(act, frm, pid, vpn);
        awaited_results.push_back(chk ? want : r);
    endtask

    // Stop offering and wait until every result has come back.
    task automatic settle();
        i_valid <= 1'b0;
        while (awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_ring(input logic [CFG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        ring_cfg = value;
        i_cfg_we <= 1'b0;
    endtask

    // Result side: compare each accepted result with the oldest one awaited.
    always @(posedge i_clk) begin : result_check
        t_page_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
            if (awaited_results.size() == 0) begin
                report("result with nothing awaited, victim", 64'(o_victim_frame), 64'd0);
            end else begin
                want = awaited_results.pop_front();
                if (o_status !== want.status) begin
                    report("status", 64'(o_status), 64'(want.status));
                end
                if (o_victim_frame !== want.victim) begin
                    report("victim_frame", 64'(o_victim_frame), 64'(want.victim));
                end
                if (o_old_valid !== want.old_valid) begin
                    report("old_valid", 64'(o_old_valid), 64'(want.old_valid));
                end
                if (o_old_pid !== want.old_pid) begin
                    report("old_pid", 64'(o_old_pid), 64'(want.old_pid));
                end
                if (o_old_vpn !== want.old_vpn) begin
                    report("old_vpn", 64'(o_old_vpn), 64'(want.old_vpn));
                end
            end
            results_seen++;
        end
    end

    // Watchdog on cycles in which neither side moves a request or a result.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) === 1'b1 || (o_valid && i_ready) === 1'b1) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d quiet cycles, %0d results still awaited",
                     quiet_cycles, awaited_results.size());
            $display("clock_page_replacement_test: done, errors");
            $finish;
        end
    end

    // Receiver pacing: random stalls, one long hold-off on request, none when idling is off.
    initial begin : result_pacing
        int span;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                i_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                span = $urandom_range(1, 13);
                i_ready <= 1'b0;
                repeat (span) @(posedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Main sequence: reset, directed script, then random phases over several ring sizes.
    initial begin : stimulus
        int k;
        int p;
        int j;
        int f;
        int n;
        logic act;
        logic [FRAME_W-1:0] frm;
        t_page_result want;

        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_action   <= ACT_TOUCH;
        i_frame    <= '0;
        i_new_pid  <= '0;
        i_new_vpn  <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= '0;
        idle_on        = 1'b1;
        hold_off_req   = 1'b0;
        mismatch_count = 0;
        results_seen   = 0;
        touch_count    = 0;
        off_ring_count = 0;
        replace_count  = 0;
        longest_sweep  = 0;
        full_laps      = 0;
        hand_pos       = 0;
        ring_cfg       = CFG_RESET;
        for (k = 0; k < NUM_FRAMES; k++) begin
            referenced[k] = 1'b0;
            filled[k]     = 1'b0;
            owner[k]      = '0;
            vpage[k]      = '0;
        end

        script = '{
            // Empty table: touches of unfilled frames, first fills.
            '{ROW_REQ, ACT_TOUCH,   8'd0,   16'h0000, 36'h0,           9'd0,   1'b1, STAT_OK,    8'd0},
            '{ROW_REQ, ACT_REPLACE, 8'd0,   16'hFFFF, 36'hF_FFFF_FFFF, 9'd0,   1'b1, STAT_OK,    8'd0},
            '{ROW_REQ, ACT_TOUCH,   8'd0,   16'h0000, 36'h0,           9'd0,   1'b1, STAT_OK,    8'd0},
            '{ROW_REQ, ACT_REPLACE, 8'd0,   16'h1234, 36'h5,           9'd0,   1'b1, STAT_OK,    8'd1},
            '{ROW_REQ, ACT_TOUCH,   8'd255, 16'h0000, 36'h0,           9'd0,   1'b1, STAT_OK,    8'd0},
            '{ROW_REQ, ACT_REPLACE, 8'd255, 16'h0000, 36'h0,           9'd0,   1'b1, STAT_OK,    8'd2},
            // Two-frame ring: touches past the ring, hand restart, all bits set.
            '{ROW_CFG, ACT_TOUCH,   8'd0,   16'h0000, 36'h0,           9'd2,   1'b0, STAT_OK,    8'd0},
            '{ROW_REQ, ACT_TOUCH,   8'd2,   16'h0000, 36'h0,           9'd0,   1'b1, STAT_RANGE, 8'd0},
            '{ROW_REQ, ACT_TOUCH,   8'd255, 16'h0000, 36'h0,           9'd0,   1'b1, STAT_RANGE, 8'd0},
            '{ROW_REQ, ACT_REPLACE, 8'd0,   16'hA5A5, 36'h9_8765_4321, 9'd0,   1'b0, STAT_OK,    8'd0},
            '{ROW_REQ, ACT_TOUCH,   8'd0,   16'h0000, 36'h0,           9'd0,   1'b1, STAT_OK,    8'd0},
            '{ROW_REQ, ACT_TOUCH,   8'd1,   16'h0000, 36'h0,           9'd0,   1'b1, STAT_OK,    8'd0},
            '{ROW_REQ, ACT_REPLACE, 8'd0,   16'h5A5A, 36'h0_0000_FFFF, 9'd0,   1'b0, STAT_OK,    8'd0},
            // A ring size of zero behaves as one frame.
            '{ROW_CFG, ACT_TOUCH,   8'd0,   16'h0000, 36'h0,           9'd0,   1'b0, STAT_OK,    8'd0},
            '{ROW_REQ, ACT_TOUCH,   8'd1,   16'h0000, 36'h0,           9'd0,   1'b1, STAT_RANGE, 8'd0},
            '{ROW_REQ, ACT_TOUCH,   8'd0,   16'h0000, 36'h0,           9'd0,   1'b1, STAT_OK,    8'd0},
            '{ROW_REQ, ACT_REPLACE, 8'd0,   16'h0001, 36'h1,           9'd0,   1'b0, STAT_OK,    8'd0},
            '{ROW_REQ, ACT_REPLACE, 8'd0,   16'h7FFF, 36'h8_0000_0000, 9'd0,   1'b0, STAT_OK,    8'd0},
            // An oversize ring behaves as the full table.
            '{ROW_CFG, ACT_TOUCH,   8'd0,   16'h0000, 36'h0,           9'd511, 1'b0, STAT_OK,    8'd0},
            '{ROW_REQ, ACT_TOUCH,   8'd255, 16'h0000, 36'h0,           9'd0,   1'b1, STAT_OK,    8'd0},
            '{ROW_REQ, ACT_REPLACE, 8'd0,   16'h8000, 36'h8_0000_0001, 9'd0,   1'b0, STAT_OK,    8'd0},
            '{ROW_REQ, ACT_TOUCH,   8'd128, 16'h0000, 36'h0,           9'd0,   1'b1, STAT_OK,    8'd0},
            // Ring of one frame written directly.
            '{ROW_CFG, ACT_TOUCH,   8'd0,   16'h0000, 36'h0,           9'd1,   1'b0, STAT_OK,    8'd0},
            '{ROW_REQ, ACT_REPLACE, 8'd0,   16'hFFFE, 36'hF_FFFF_FFFE, 9'd0,   1'b0, STAT_OK,    8'd0},
            '{ROW_REQ, ACT_TOUCH,   8'd0,   16'h0000, 36'h0,           9'd0,   1'b1, STAT_OK,    8'd0},
            '{ROW_REQ, ACT_REPLACE, 8'd0,   16'h0000, 36'h0,           9'd0,   1'b0, STAT_OK,    8'd0},
            '{ROW_CFG, ACT_TOUCH,   8'd0,   16'h0000, 36'h0,           9'd256, 1'b0, STAT_OK,    8'd0}
        };
        phase_ring = '{256, 1, 3, 16, 0, 255, 511, 64, 7, 2, 256};

        // Hold synchronous reset, then release it.
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed script.
        for (k = 0; k < SCRIPT_LEN; k++) begin
            if (script[k].kind == ROW_CFG) begin
                settle();
                set_ring(script[k].ring);
            end else begin
                want = '0;
                want.status = script[k].w_status;
                want.victim = script[k].w_victim;
                offer(script[k].act, script[k].frame, script[k].pid, script[k].vpn,
                      script[k].chk, want);
            end
        end

        // Random phases, one ring size each; the last two run without idling.
        for (p = 0; p < PHASES; p++) begin
            settle();
            set_ring(CFG_W'(phase_ring[p]));
            idle_on = (p < PHASES - 2);
            if (p == 2) begin
                hold_off_req = 1'b1;
            end
            n = ring_frames();
            for (j = 0; j < RANDOM_PER_RING; j++) begin
                act = ($urandom_range(0, 99) < 35) ? ACT_REPLACE : ACT_TOUCH;
                if ($urandom_range(0, 9) == 0) begin
                    frm = FRAME_W'($urandom_range(0, NUM_FRAMES - 1));
                end else begin
                    frm = FRAME_W'($urandom_range(0, n - 1));
                end
                offer(act, frm, rand_pid(), rand_vpn(), 1'b0, '0);
            end
            // On the 64- and 255-frame rings, touch every frame and then force a long sweep.
            if (n == 64 || n == 255) begin
                for (f = 0; f < n; f++) begin
                    offer(ACT_TOUCH, FRAME_W'(f), rand_pid(), rand_vpn(), 1'b0, '0);
                end
                offer(ACT_REPLACE, '0, rand_pid(), rand_vpn(), 1'b0, '0);
            end
        end

        settle();
        repeat (8) @(posedge i_clk);

        $display("covered %0d touches (%0d outside the ring) and %0d replaces over %0d ring sizes",
                 touch_count, off_ring_count, replace_count, PHASES + 4);
        $display("longest sweep cleared %0d reference bits; %0d sweeps went all the way round",
                 longest_sweep, full_laps);
        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("clock_page_replacement_test: done, clean");
        end else begin
            $display("clock_page_replacement_test: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/cpr_pkg.sv
rtl/cpr_ram.sv
rtl/cpr_ctrl.sv
rtl/clock_page_replacement.sv
sim/clock_page_replacement_test.sv
